// ===== src/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// Widths, constants and inter-module types for the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

    localparam logic [VALUE_WIDTH-1:0] VAL_ONE       = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] VAL_TWO       = VALUE_WIDTH'(2);
    localparam logic [VALUE_WIDTH-1:0] VAL_FOUR      = VALUE_WIDTH'(4);
    localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
    localparam logic [VALUE_WIDTH-1:0] FIRST_SQUARE  = VALUE_WIDTH'(9);

    // request from the sequencer to the remainder unit
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } rem_req_t;

    // status back from the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

// ===== src/trial_division_prime_test_unit.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test of a signed integer by trial division over odd divisors.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, value) takes one signed integer per
//   transfer; response channel (rsp_valid/rsp_ready, prime_flag) returns one
//   flag per request, in order.
//   Negative values, 0, 1 and even values above 2 settle with no divisor
//   walk, via ST_FINISH to rsp_valid; 2 reports prime the same way.
//   Odd values walk divisors d = 3, 5, 7, ... while d*d <= value. The square
//   is kept by increments, so each divisor costs a compare step in ST_CHECK
//   plus one bit-serial remainder run in ST_DIV, about 23170 divisors for
//   the largest 32-bit primes.
//   req_ready is high only while the sequencer is idle; one item is worked on
//   at a time.
//   The result sits in an output register, so a new request is taken while a
//   response waits; if the receiver stalls and a second result is finished,
//   the sequencer holds it until the output register frees up.
//   Reset (rst_n, asynchronous, active low) empties the output register and
//   returns the sequencer to idle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic                                prime_flag
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] val_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] val_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] div_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] div_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] sq_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] sq_next;
    logic                             flag_reg;
    logic                             flag_next;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    logic                             prime_reg;
    logic                             prime_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] uval;
    logic                             req_xfer;
    tdpt_pkg::rem_req_t               rem_req;
    tdpt_pkg::rem_stat_t              rem_stat;

    assign uval      = $unsigned(value);
    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;

    assign rem_req.start    = (state_reg == ST_CHECK) && (sq_reg <= val_reg);
    assign rem_req.dividend = val_reg;
    assign rem_req.divisor  = div_reg;

    tdpt_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        flag_next      = flag_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        prime_next     = prime_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    val_next = uval;
                    div_next = tdpt_pkg::FIRST_DIVISOR;
                    sq_next  = tdpt_pkg::FIRST_SQUARE;
                    if (uval[tdpt_pkg::VALUE_WIDTH-1] || uval == '0 ||
                        uval == tdpt_pkg::VAL_ONE)
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else if (uval == tdpt_pkg::VAL_TWO)
                    begin
                        flag_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (!uval[0])
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg <= val_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    flag_next  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        div_next   = div_reg + tdpt_pkg::VAL_TWO;
                        sq_next    = sq_reg + {div_reg[tdpt_pkg::VALUE_WIDTH-3:0], 2'b00}
                                     + tdpt_pkg::VAL_FOUR;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    prime_next     = flag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        div_reg   <= div_next;
        sq_reg    <= sq_next;
        flag_reg  <= flag_next;
        prime_reg <= prime_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign prime_flag = prime_reg;

    a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_DIV) |-> div_reg[0])
        else $error("trial divisor is even");

    a_start_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        rem_req.start |=> state_reg == ST_DIV)
        else $error("remainder run started outside the compare step");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> state_reg == ST_DIV)
        else $error("remainder result arrived with no run pending");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> rem_stat.busy || rem_stat.done)
        else $error("sequencer waits on an idle remainder unit");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> state_reg != ST_IDLE)
        else $error("request transfer did not start work");

endmodule

// ===== src/tdpt_rem_unit.sv =====
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_rem_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  tdpt_pkg::rem_req_t  req,
    output tdpt_pkg::rem_stat_t stat
);

    logic                             busy_reg;
    logic                             busy_next;
    logic                             done_reg;
    logic                             done_next;
    logic [tdpt_pkg::CNT_WIDTH-1:0]   cnt_reg;
    logic [tdpt_pkg::CNT_WIDTH-1:0]   cnt_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] quo_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] quo_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] rem_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] rem_next;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] dsr_reg;
    logic [tdpt_pkg::VALUE_WIDTH-1:0] dsr_next;
    logic [tdpt_pkg::VALUE_WIDTH:0]   trial;

    assign trial = {rem_reg, quo_reg[tdpt_pkg::VALUE_WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = tdpt_pkg::CNT_WIDTH'(tdpt_pkg::VALUE_WIDTH);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // restore unless the trial remainder covers the divisor
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = tdpt_pkg::VALUE_WIDTH'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[tdpt_pkg::VALUE_WIDTH-1:0];
            end
            quo_next = {quo_reg[tdpt_pkg::VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - tdpt_pkg::CNT_WIDTH'(1);
            if (cnt_reg == tdpt_pkg::CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("remainder unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a preceding run");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg && cnt_reg == tdpt_pkg::CNT_WIDTH'(tdpt_pkg::VALUE_WIDTH))
        else $error("start did not load the bit counter");

endmodule

// ===== bench/trial_division_prime_test_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit_tb
// Self-checking bench for the trial division prime test unit.
// A queue of values feeds a request driver. A monitor works out the expected
// flag for each request transfer by its own trial division and checks each
// response transfer in order. Both channels idle at random, with quiet
// windows in which neither side idles. A watchdog ends the run if the channels
// stay silent too long.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit_tb;

    localparam int RANDOM_ITEMS = 78;
    localparam int DRAIN_CYCLES = 50;
    // the largest 32-bit prime walks about 23170 divisors
    localparam int SILENCE_LIMIT = 3_000_000;

    localparam logic [tdpt_pkg::VALUE_WIDTH-1:0] CORNER_VALUES [22] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd25, 32'd97,
        32'd63001,              // 251 squared: divisor square equals the value
        32'd65521, 32'd65535,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFD, 32'h8000_0000, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h7FFF_FFFD, 32'h7FFF_FFFE,
        32'h7FFF_FFFF           // largest positive value, and prime
    };

    typedef struct {
        logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value;
        logic                                    flag;
    } prime_verdict_t;

    logic                                    clk        = 1'b0;
    logic                                    rst_n      = 1'b0;
    logic                                    req_valid  = 1'b0;
    logic                                    req_ready;
    logic signed [tdpt_pkg::VALUE_WIDTH-1:0] value      = '0;
    logic                                    rsp_valid;
    logic                                    rsp_ready  = 1'b0;
    logic                                    prime_flag;

    logic signed [tdpt_pkg::VALUE_WIDTH-1:0] pending_values [$];
    prime_verdict_t                          verdicts_due [$];
    int                                      mismatch_count = 0;
    int                                      silent_cycles  = 0;
    logic [31:0]                             cycle_count    = '0;
    wire                                     quiet_window   = (cycle_count[11:10] == 2'b00);

    trial_division_prime_test_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .value      (value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .prime_flag (prime_flag)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic predict_prime(logic signed [tdpt_pkg::VALUE_WIDTH-1:0] v);
        logic [63:0] u;
        logic [63:0] d;
        u = {{(64-tdpt_pkg::VALUE_WIDTH){1'b0}}, v};
        if (v[tdpt_pkg::VALUE_WIDTH-1])
            return 1'b0;
        if (u <= 1)
            return 1'b0;
        if (u == 2)
            return 1'b1;
        if (!u[0])
            return 1'b0;
        for (d = 3; d * d <= u; d += 2)
        begin
            if (u % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        mismatch_count++;
    endtask

    // request driver: advance to the next value once the current one transfers
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_ready)
        begin
            if (pending_values.size() != 0 && (quiet_window || $urandom_range(99) >= 32))
            begin
                req_valid <= 1'b1;
                value     <= pending_values.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= quiet_window || ($urandom_range(99) >= 32);
    end

    always @(posedge clk)
    begin
        prime_verdict_t due;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (req_valid && req_ready)
                verdicts_due.push_back('{value: value, flag: predict_prime(value)});
            if (rsp_valid && rsp_ready)
            begin
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("response flag %0b with no request pending",
                                              prime_flag));
                else
                begin
                    due = verdicts_due.pop_front();
                    if (prime_flag !== due.flag)
                        report_mismatch($sformatf("value %0d: prime_flag %0b, expected %0b",
                                                  due.value, prime_flag, due.flag));
                end
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                silent_cycles <= 0;
            else
                silent_cycles <= silent_cycles + 1;
        end
    end

    initial
    begin
        while (silent_cycles < SILENCE_LIMIT)
            @(negedge clk);
        $display("watchdog: no transfer for %0d cycles", SILENCE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic signed [tdpt_pkg::VALUE_WIDTH-1:0] v;
        int unsigned                             pick;
        int unsigned                             p;
        int unsigned                             q;

        foreach (CORNER_VALUES[i])
            pending_values.push_back(CORNER_VALUES[i]);

        // keep positive odd values small or with a small factor so the walk stays short
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                v = $urandom_range(2047, 1) * 2 + 1;
            else if (pick < 45)
                v = $urandom_range(32767, 1) * 2 + 1;
            else if (pick < 60)
            begin
                p = $urandom_range(255, 3) | 1;
                q = $urandom_range(32'h7FFF_FFFF / p, 1);
                v = p * q;
            end
            else if (pick < 70)
            begin
                p = $urandom_range(255, 3) | 1;
                v = p * p;
            end
            else if (pick < 85)
                v = $urandom | 32'h8000_0000;
            else if (pick < 95)
                v = $urandom & ~32'd1;
            else
                v = int'($urandom_range(5)) - 2;
            pending_values.push_back(v);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || req_valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== trial_division_prime_test_unit.f =====
src/tdpt_pkg.sv
src/tdpt_rem_unit.sv
src/trial_division_prime_test_unit.sv
bench/trial_division_prime_test_unit_tb.sv
